### rtl/pce_pkg.sv
// Package for the point charge Coulomb energy unit.
// Types, constants and state codes shared by the store, the sqrt/divide unit and the top level.
package pce_pkg;

   localparam int MAX_POINTS = 256;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);

   localparam int CHG_W = 24;
   localparam int POS_W = 32;
   localparam int ACC_W = 64;
   localparam int SUM_W = 66;   // exact sum of three squared distances
   localparam int DVD_W = 56;   // |qa*qb| << 8
   localparam int DSR_W = 33;   // floor(sqrt(S))
   localparam int REM_W = 36;
   localparam int SQRT_STEPS = SUM_W / 2;
   localparam int DIV_STEPS  = DVD_W;
   localparam int STEP_W     = $clog2(DIV_STEPS + 1);

   localparam logic [1:0] CSR_FIELD_X = 2'd0;
   localparam logic [1:0] CSR_FIELD_Y = 2'd1;
   localparam logic [1:0] CSR_FIELD_Z = 2'd2;

   localparam logic [2:0] SLOT_NN = 3'd0;
   localparam logic [2:0] SLOT_EE = 3'd1;
   localparam logic [2:0] SLOT_NE = 3'd2;
   localparam logic [2:0] SLOT_NF = 3'd3;
   localparam logic [2:0] SLOT_EF = 3'd4;
   localparam int NUM_SLOTS = 5;

   typedef struct packed {
      logic signed [CHG_W-1:0] charge;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic                    grp;
   } entry_type;

   typedef enum logic [0:0] {
      MODE_SQRT,
      MODE_DIV
   } sd_mode_type;

   typedef struct packed {
      logic        start;
      sd_mode_type mode;
   } sd_ctl_type;

   typedef enum logic [1:0] {
      PH_LIKE,
      PH_MIX,
      PH_FIELD
   } phase_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_RDA,
      S_LDA,
      S_RDB,
      S_LDB,
      S_SQX,
      S_SQY,
      S_SQZ,
      S_QQ,
      S_CHK,
      S_SQRT,
      S_DIV,
      S_PACC,
      S_FX,
      S_FY,
      S_FZ,
      S_FD,
      S_FM0,
      S_FM1,
      S_FM2,
      S_FACC,
      S_OUT
   } state_type;

endpackage

### rtl/pce_store.sv
// Point store: one write port for loading, one registered read port for the sequencer.
// Depends on pce_pkg.
module pce_store import pce_pkg::*; (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  entry_type        wr_data,
   input  logic [IDX_W-1:0] rd_addr,
   output entry_type        rd_data
);

   entry_type mem [MAX_POINTS];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/pce_sqdiv.sv
// Bit-serial integer square root and restoring divider sharing one subtractor.
// Depends on pce_pkg.
module pce_sqdiv import pce_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  sd_ctl_type       ctl,
   input  logic [SUM_W-1:0] radicand,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DSR_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] result
);

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   sd_mode_type       mode_ff, mode_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [SUM_W-1:0]  sh_ff, sh_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [DVD_W-1:0]  q_ff, q_in;
   logic [DSR_W-1:0]  d_ff, d_in;

   logic [REM_W-1:0]  rem_sh;
   logic [REM_W-1:0]  trial;
   logic [REM_W:0]    diff;
   logic              last_step;

   always_comb begin
      if (mode_ff == MODE_SQRT) begin
         rem_sh    = {rem_ff[REM_W-3:0], sh_ff[SUM_W-1 -: 2]};
         trial     = {q_ff[REM_W-3:0], 2'b01};
         last_step = (cnt_ff == STEP_W'(SQRT_STEPS - 1));
      end else begin
         rem_sh    = {rem_ff[REM_W-2:0], sh_ff[SUM_W-1]};
         trial     = {{(REM_W-DSR_W){1'b0}}, d_ff};
         last_step = (cnt_ff == STEP_W'(DIV_STEPS - 1));
      end
      diff = {1'b0, rem_sh} - {1'b0, trial};
   end

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      mode_in = mode_ff;
      cnt_in  = cnt_ff;
      sh_in   = sh_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      d_in    = d_ff;
      if (ctl.start) begin
         run_in  = 1'b1;
         mode_in = ctl.mode;
         cnt_in  = '0;
         rem_in  = '0;
         q_in    = '0;
         d_in    = divisor;
         if (ctl.mode == MODE_SQRT) begin
            sh_in = radicand;
         end else begin
            sh_in = {dividend, {(SUM_W-DVD_W){1'b0}}};
         end
      end else if (run_ff) begin
         if (diff[REM_W]) begin
            rem_in = rem_sh;
            q_in   = {q_ff[DVD_W-2:0], 1'b0};
         end else begin
            rem_in = diff[REM_W-1:0];
            q_in   = {q_ff[DVD_W-2:0], 1'b1};
         end
         if (mode_ff == MODE_SQRT) begin
            sh_in = {sh_ff[SUM_W-3:0], 2'b00};
         end else begin
            sh_in = {sh_ff[SUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + STEP_W'(1);
         if (last_step) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      mode_ff <= mode_in;
      cnt_ff  <= cnt_in;
      sh_ff   <= sh_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      d_ff    <= d_in;
   end

   assign done   = done_ff;
   assign result = q_ff;

endmodule

### rtl/point_charge_coulomb_energy_unit.sv
// Top level of the point charge Coulomb energy unit: load handshake, sequencer and datapath.
// Depends on pce_pkg, pce_store and pce_sqdiv.
//
// Points are loaded one beat per cycle while busy is low; up to 256 are kept, later ones are
// dropped and flagged. A beat with last set starts the compute and raises busy. Each same-group
// or nucleus/external pair that is evaluated runs the 33-step square root and then the 56-step
// divide of the shared bit-serial unit; a pair outside the wanted grouping or a coincident pair
// skips both, and every point then adds a field term. The result beat is on the rsp_ ports for
// one cycle with rsp_valid; the receiver cannot stall it. busy drops the cycle after, with the
// store empty.
module point_charge_coulomb_energy_unit import pce_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic signed [CHG_W-1:0] req_charge,
   input  logic signed [POS_W-1:0] req_pos_x,
   input  logic signed [POS_W-1:0] req_pos_y,
   input  logic signed [POS_W-1:0] req_pos_z,
   input  logic                    req_group,
   input  logic                    req_last,
   output logic                    rsp_valid,
   output logic signed [ACC_W-1:0] rsp_nuc_nuc_energy,
   output logic signed [ACC_W-1:0] rsp_ext_ext_energy,
   output logic signed [ACC_W-1:0] rsp_nuc_ext_energy,
   output logic signed [ACC_W-1:0] rsp_nuc_field_energy,
   output logic signed [ACC_W-1:0] rsp_ext_field_energy,
   output logic                    rsp_coincident_seen,
   output logic                    rsp_saturated,
   output logic                    rsp_dropped,
   input  logic                    csr_we,
   input  logic [1:0]              csr_index,
   input  logic [POS_W-1:0]        csr_wdata
);

   state_type  state_ff, state_in;
   phase_type  phase_ff, phase_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [CNT_W-1:0] a_ff, a_in;
   logic [CNT_W-1:0] b_ff, b_in;
   logic drop_ff, drop_in;
   logic coin_ff, coin_in;
   logic sat_ff, sat_in;

   logic signed [POS_W-1:0] fx_ff, fy_ff, fz_ff;
   entry_type ea_ff, ea_in;
   entry_type eb_ff, eb_in;

   logic [2*POS_W-1:0]      mul_ff;
   logic                    mul_neg_ff;
   logic [POS_W-1:0]        mul_a, mul_b;
   logic                    mul_neg;
   logic [SUM_W-1:0]        s_ff, s_in;
   logic signed [SUM_W-1:0] dot_ff, dot_in;
   logic [87:0]             prod_ff, prod_in;
   logic signed [ACC_W-1:0] acc_ff [NUM_SLOTS];

   logic                    add_en;
   logic [2:0]              add_slot;
   logic signed [ACC_W-1:0] add_term;
   logic signed [ACC_W:0]   add_sum;
   logic signed [ACC_W-1:0] add_res;
   logic                    add_ovf;
   logic                    acc_clr;

   logic             wr_en;
   entry_type        wr_data;
   logic [IDX_W-1:0] rd_addr;
   entry_type        rd_data;

   sd_ctl_type       sd_ctl;
   logic             sd_done;
   logic [DVD_W-1:0] sd_result;

   logic signed [POS_W:0] dx, dy, dz;
   logic [POS_W-1:0]      mdx, mdy, mdz;
   logic [CHG_W-1:0]      mqa, mqb;
   logic [POS_W-1:0]      mpx, mpy, mpz, mfx, mfy, mfz;
   logic [SUM_W-1:0]      dm_wide;
   logic [ACC_W-1:0]      dm;
   logic signed [SUM_W-1:0] mul_signed;
   logic [ACC_W-1:0]      pair_mag;
   logic signed [ACC_W-1:0] pair_term;
   logic [ACC_W-1:0]      fmag;
   logic                  fneg;
   logic signed [ACC_W-1:0] field_term;
   logic                  field_sat;
   logic                  accept;
   logic                  store_ok;
   logic [CNT_W-1:0]      b_limit;

   pce_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pce_sqdiv u_sqdiv (
      .clock    (clock),
      .reset    (reset),
      .ctl      (sd_ctl),
      .radicand (s_ff),
      .dividend ({mul_ff[DVD_W-9:0], 8'd0}),
      .divisor  (sd_result[DSR_W-1:0]),
      .done     (sd_done),
      .result   (sd_result)
   );

   assign accept   = start && (state_ff == S_IDLE);
   assign store_ok = (count_ff != CNT_W'(MAX_POINTS));
   assign wr_en    = accept && store_ok;
   assign wr_data  = '{charge: req_charge, pos_x: req_pos_x, pos_y: req_pos_y,
                       pos_z: req_pos_z, grp: req_group};

   always_comb begin
      dx  = {ea_ff.pos_x[POS_W-1], ea_ff.pos_x} - {eb_ff.pos_x[POS_W-1], eb_ff.pos_x};
      dy  = {ea_ff.pos_y[POS_W-1], ea_ff.pos_y} - {eb_ff.pos_y[POS_W-1], eb_ff.pos_y};
      dz  = {ea_ff.pos_z[POS_W-1], ea_ff.pos_z} - {eb_ff.pos_z[POS_W-1], eb_ff.pos_z};
      mdx = dx[POS_W] ? POS_W'(-dx) : dx[POS_W-1:0];
      mdy = dy[POS_W] ? POS_W'(-dy) : dy[POS_W-1:0];
      mdz = dz[POS_W] ? POS_W'(-dz) : dz[POS_W-1:0];
      mqa = ea_ff.charge[CHG_W-1] ? CHG_W'(-ea_ff.charge) : ea_ff.charge;
      mqb = eb_ff.charge[CHG_W-1] ? CHG_W'(-eb_ff.charge) : eb_ff.charge;
      mpx = ea_ff.pos_x[POS_W-1] ? POS_W'(-ea_ff.pos_x) : ea_ff.pos_x;
      mpy = ea_ff.pos_y[POS_W-1] ? POS_W'(-ea_ff.pos_y) : ea_ff.pos_y;
      mpz = ea_ff.pos_z[POS_W-1] ? POS_W'(-ea_ff.pos_z) : ea_ff.pos_z;
      mfx = fx_ff[POS_W-1] ? POS_W'(-fx_ff) : fx_ff;
      mfy = fy_ff[POS_W-1] ? POS_W'(-fy_ff) : fy_ff;
      mfz = fz_ff[POS_W-1] ? POS_W'(-fz_ff) : fz_ff;
      dm_wide = dot_ff[SUM_W-1] ? SUM_W'(-dot_ff) : dot_ff;
      dm      = dm_wide[ACC_W-1:0];
      mul_signed = mul_neg_ff ? -$signed({2'b00, mul_ff}) : $signed({2'b00, mul_ff});
   end

   // shared multiplier operand select; |qa*qb| is held through the sqrt for the divide
   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      mul_neg = 1'b0;
      case (state_ff)
         S_SQX: begin mul_a = mdx; mul_b = mdx; end
         S_SQY: begin mul_a = mdy; mul_b = mdy; end
         S_SQZ: begin mul_a = mdz; mul_b = mdz; end
         S_QQ, S_CHK, S_SQRT: begin mul_a = POS_W'(mqa); mul_b = POS_W'(mqb); end
         S_FX: begin
            mul_a = mpx; mul_b = mfx; mul_neg = ea_ff.pos_x[POS_W-1] ^ fx_ff[POS_W-1];
         end
         S_FY: begin
            mul_a = mpy; mul_b = mfy; mul_neg = ea_ff.pos_y[POS_W-1] ^ fy_ff[POS_W-1];
         end
         S_FZ: begin
            mul_a = mpz; mul_b = mfz; mul_neg = ea_ff.pos_z[POS_W-1] ^ fz_ff[POS_W-1];
         end
         S_FM0: begin mul_a = POS_W'(mqa); mul_b = dm[POS_W-1:0]; end
         S_FM1: begin mul_a = POS_W'(mqa); mul_b = dm[ACC_W-1:POS_W]; end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   always_comb begin
      pair_mag  = {{(ACC_W-DVD_W){1'b0}}, sd_result};
      pair_term = (ea_ff.charge[CHG_W-1] != eb_ff.charge[CHG_W-1]) ?
                  -$signed(pair_mag) : $signed(pair_mag);
      fmag      = prod_ff[87:24];
      fneg      = dot_ff[SUM_W-1] ^ ea_ff.charge[CHG_W-1];
      field_sat = 1'b0;
      if (!fneg) begin
         if (fmag[ACC_W-1]) begin
            field_sat  = 1'b1;
            field_term = {1'b0, {(ACC_W-1){1'b1}}};
         end else begin
            field_term = $signed(fmag);
         end
      end else if (fmag[ACC_W-1]) begin
         field_sat  = (fmag[ACC_W-2:0] != '0);
         field_term = {1'b1, {(ACC_W-1){1'b0}}};
      end else begin
         field_term = -$signed(fmag);
      end
   end

   // shared saturating accumulator adder
   always_comb begin
      add_sum = {acc_ff[add_slot][ACC_W-1], acc_ff[add_slot]} + {add_term[ACC_W-1], add_term};
      add_ovf = (add_sum[ACC_W] != add_sum[ACC_W-1]);
      if (add_ovf) begin
         add_res = add_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         add_res = add_sum[ACC_W-1:0];
      end
   end

   assign b_limit = (phase_ff == PH_LIKE) ? a_ff : n_ff;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      count_in = count_ff;
      n_in     = n_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      drop_in  = drop_ff;
      coin_in  = coin_ff;
      sat_in   = sat_ff;
      ea_in    = ea_ff;
      eb_in    = eb_ff;
      s_in     = s_ff;
      dot_in   = dot_ff;
      prod_in  = prod_ff;
      rd_addr  = a_ff[IDX_W-1:0];
      sd_ctl   = '{start: 1'b0, mode: MODE_SQRT};
      add_en   = 1'b0;
      add_slot = SLOT_NN;
      add_term = '0;
      acc_clr  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (store_ok) begin
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  drop_in = 1'b1;
               end
               if (req_last) begin
                  n_in     = store_ok ? count_ff + CNT_W'(1) : count_ff;
                  phase_in = PH_LIKE;
                  a_in     = '0;
                  coin_in  = 1'b0;
                  sat_in   = 1'b0;
                  acc_clr  = 1'b1;
                  state_in = S_RDA;
               end
            end
         end
         S_RDA: begin
            rd_addr = a_ff[IDX_W-1:0];
            if (a_ff >= n_ff) begin
               a_in = '0;
               unique case (phase_ff)
                  PH_LIKE: begin phase_in = PH_MIX; state_in = S_RDA; end
                  PH_MIX:  begin phase_in = PH_FIELD; state_in = S_RDA; end
                  default: state_in = S_OUT;
               endcase
            end else begin
               state_in = S_LDA;
            end
         end
         S_LDA: begin
            ea_in = rd_data;
            b_in  = '0;
            if (phase_ff == PH_FIELD) begin
               state_in = S_FX;
            end else if (phase_ff == PH_MIX && rd_data.grp) begin
               a_in     = a_ff + CNT_W'(1);
               state_in = S_RDA;
            end else begin
               state_in = S_RDB;
            end
         end
         S_RDB: begin
            rd_addr = b_ff[IDX_W-1:0];
            if (b_ff >= b_limit) begin
               a_in     = a_ff + CNT_W'(1);
               state_in = S_RDA;
            end else begin
               state_in = S_LDB;
            end
         end
         S_LDB: begin
            eb_in = rd_data;
            if ((phase_ff == PH_LIKE) ? (rd_data.grp == ea_ff.grp) : rd_data.grp) begin
               state_in = S_SQX;
            end else begin
               b_in     = b_ff + CNT_W'(1);
               state_in = S_RDB;
            end
         end
         S_SQX: begin s_in = '0; state_in = S_SQY; end
         S_SQY: begin s_in = s_ff + SUM_W'(mul_ff); state_in = S_SQZ; end
         S_SQZ: begin s_in = s_ff + SUM_W'(mul_ff); state_in = S_QQ; end
         S_QQ:  begin s_in = s_ff + SUM_W'(mul_ff); state_in = S_CHK; end
         S_CHK: begin
            if (s_ff == '0) begin
               coin_in  = 1'b1;
               b_in     = b_ff + CNT_W'(1);
               state_in = S_RDB;
            end else begin
               sd_ctl   = '{start: 1'b1, mode: MODE_SQRT};
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            if (sd_done) begin
               sd_ctl   = '{start: 1'b1, mode: MODE_DIV};
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (sd_done) begin
               state_in = S_PACC;
            end
         end
         S_PACC: begin
            add_en   = 1'b1;
            add_slot = (phase_ff == PH_LIKE) ? (ea_ff.grp ? SLOT_EE : SLOT_NN) : SLOT_NE;
            add_term = pair_term;
            b_in     = b_ff + CNT_W'(1);
            state_in = S_RDB;
         end
         S_FX: begin dot_in = '0; state_in = S_FY; end
         S_FY: begin dot_in = dot_ff + mul_signed; state_in = S_FZ; end
         S_FZ: begin dot_in = dot_ff + mul_signed; state_in = S_FD; end
         S_FD: begin dot_in = dot_ff + mul_signed; state_in = S_FM0; end
         S_FM0: state_in = S_FM1;
         S_FM1: begin prod_in = {24'd0, mul_ff}; state_in = S_FM2; end
         S_FM2: begin prod_in = prod_ff + {mul_ff[55:0], 32'd0}; state_in = S_FACC; end
         S_FACC: begin
            add_en   = 1'b1;
            add_slot = ea_ff.grp ? SLOT_EF : SLOT_NF;
            add_term = field_term;
            if (field_sat) begin
               sat_in = 1'b1;
            end
            a_in     = a_ff + CNT_W'(1);
            state_in = S_RDA;
         end
         S_OUT: begin
            count_in = '0;
            drop_in  = 1'b0;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      if (add_en && add_ovf) begin
         sat_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         drop_ff  <= 1'b0;
         fx_ff    <= '0;
         fy_ff    <= '0;
         fz_ff    <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         drop_ff  <= drop_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_FIELD_X: fx_ff <= csr_wdata;
               CSR_FIELD_Y: fy_ff <= csr_wdata;
               CSR_FIELD_Z: fz_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
      phase_ff   <= phase_in;
      n_ff       <= n_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      coin_ff    <= coin_in;
      sat_ff     <= sat_in;
      ea_ff      <= ea_in;
      eb_ff      <= eb_in;
      s_ff       <= s_in;
      dot_ff     <= dot_in;
      prod_ff    <= prod_in;
      mul_ff     <= mul_a * mul_b;
      mul_neg_ff <= mul_neg;
      for (int k = 0; k < NUM_SLOTS; k++) begin
         if (acc_clr) begin
            acc_ff[k] <= '0;
         end else if (add_en && add_slot == 3'(k)) begin
            acc_ff[k] <= add_res;
         end
      end
   end

   assign busy                 = (state_ff != S_IDLE);
   assign rsp_valid            = (state_ff == S_OUT);
   assign rsp_nuc_nuc_energy   = acc_ff[SLOT_NN];
   assign rsp_ext_ext_energy   = acc_ff[SLOT_EE];
   assign rsp_nuc_ext_energy   = acc_ff[SLOT_NE];
   assign rsp_nuc_field_energy = acc_ff[SLOT_NF];
   assign rsp_ext_field_energy = acc_ff[SLOT_EF];
   assign rsp_coincident_seen  = coin_ff;
   assign rsp_saturated        = sat_ff;
   assign rsp_dropped          = drop_ff;

   a_rsp_one_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result beat held longer than one cycle");

   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result beat while idle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_POINTS))
      else $error("store count past capacity");

   a_clear_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (count_ff == '0 && !drop_ff && !busy))
      else $error("store not cleared after result");

endmodule
